/* design/thermostat_mode_controller_defines.svh */
// Assertion helpers shared by the thermostat controller modules.
`ifndef THERMOSTAT_MODE_CONTROLLER_DEFINES_SVH
`define THERMOSTAT_MODE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define TMC_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define TMC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/tmc_pkg.sv */
package tmc_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_HYSTERESIS     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COOLING_ENABLE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEAT_ON_DELAY  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEAT_OFF_DELAY = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_COOL_ON_DELAY  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_COOL_OFF_DELAY = 3'd5;

    localparam logic [9:0] HYSTERESIS_RESET = 10'd16;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_HEAT = 2'd1,
        MODE_COOL = 2'd2
    } mode_t;

    typedef struct packed {
        logic signed [15:0] temperature;
        logic signed [15:0] setpoint;
        logic [31:0]        now_tick;
    } tmc_in_t;

    typedef struct packed {
        logic       heat_on;
        logic       cooler_on;
        logic [1:0] active_mode;
        logic       running;
        logic       transition_pending;
    } tmc_out_t;

    typedef struct packed {
        logic [9:0]  hysteresis;
        logic        cooling_enable;
        logic [30:0] heat_on_delay;
        logic [30:0] heat_off_delay;
        logic [30:0] cool_on_delay;
        logic [30:0] cool_off_delay;
    } tmc_cfg_t;

    localparam tmc_cfg_t CFG_RESET = '{
        hysteresis:     HYSTERESIS_RESET,
        cooling_enable: 1'b0,
        heat_on_delay:  31'd0,
        heat_off_delay: 31'd0,
        cool_on_delay:  31'd0,
        cool_off_delay: 31'd0
    };

endpackage

/* design/tmc_cfg_regs.sv */
module tmc_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tmc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tmc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output tmc_pkg::tmc_cfg_t                cfg
);
    import tmc_pkg::*;

    tmc_cfg_t cfg_reg;
    tmc_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_HYSTERESIS:     cfg_next.hysteresis     = cfg_data[9:0];
                CFG_COOLING_ENABLE: cfg_next.cooling_enable = cfg_data[0];
                CFG_HEAT_ON_DELAY:  cfg_next.heat_on_delay  = cfg_data[30:0];
                CFG_HEAT_OFF_DELAY: cfg_next.heat_off_delay = cfg_data[30:0];
                CFG_COOL_ON_DELAY:  cfg_next.cool_on_delay  = cfg_data[30:0];
                CFG_COOL_OFF_DELAY: cfg_next.cool_off_delay = cfg_data[30:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* design/tmc_core.sv */
`include "thermostat_mode_controller_defines.svh"

module tmc_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  tmc_pkg::tmc_in_t  item,
    input  tmc_pkg::tmc_cfg_t cfg,
    output tmc_pkg::tmc_out_t result
);
    import tmc_pkg::*;

    mode_t       mode_reg, mode_next;
    logic        pend_reg, pend_next;
    mode_t       target_reg, target_next;
    logic [31:0] due_reg, due_next;
    logic        rest_reg, rest_next;

    logic signed [18:0] diff;
    logic signed [18:0] h1;
    logic signed [18:0] h2;
    logic               le_neg_h, ge_h, le_neg_2h, ge_2h, in_band;
    mode_t              want;
    logic [30:0]        delay;
    logic [31:0]        since_due;

    // diff = 2*temperature - 2*setpoint
    always_comb begin
        diff = ({{3{item.temperature[15]}}, item.temperature}
              - {{3{item.setpoint[15]}}, item.setpoint}) <<< 1;
        h1   = signed'({9'b0, cfg.hysteresis});
        h2   = h1 <<< 1;
    end

    assign le_neg_h  = diff <= -h1;
    assign ge_h      = diff >= h1;
    assign le_neg_2h = diff <= -h2;
    assign ge_2h     = diff >= h2;
    assign in_band   = (diff > -h2) && (diff < h2);

    always_comb begin
        rest_next = rest_reg || (mode_reg == MODE_COOL && le_neg_h);
        if (rest_next && ge_h) begin
            rest_next = 1'b0;
        end
        if (rest_next && le_neg_2h) begin
            rest_next = 1'b0;
        end

        if (le_neg_2h) begin
            want = MODE_HEAT;
        end else if (cfg.cooling_enable && ge_2h) begin
            want = MODE_COOL;
        end else if (in_band) begin
            if (mode_reg == MODE_HEAT && diff >= 0) begin
                want = MODE_IDLE;
            end else if (mode_reg == MODE_COOL && diff <= 0) begin
                want = MODE_IDLE;
            end else begin
                want = mode_reg;
            end
        end else begin
            want = MODE_IDLE;
        end
        if (rest_next && want == MODE_COOL) begin
            want = MODE_IDLE;
        end

        case (want)
            MODE_HEAT: delay = cfg.heat_on_delay;
            MODE_COOL: delay = cfg.cool_on_delay;
            default: begin
                if (mode_reg == MODE_HEAT) begin
                    delay = cfg.heat_off_delay;
                end else if (mode_reg == MODE_COOL) begin
                    delay = cfg.cool_off_delay;
                end else begin
                    delay = '0;
                end
            end
        endcase

        pend_next   = pend_reg;
        target_next = target_reg;
        due_next    = due_reg;
        mode_next   = mode_reg;
        if (!pend_reg && want != mode_reg) begin
            pend_next   = 1'b1;
            target_next = want;
            due_next    = item.now_tick + {1'b0, delay};
        end
        // wrap-safe: due reached when now - due is in the lower half range
        since_due = item.now_tick - due_next;
        if (pend_next && !since_due[31]) begin
            mode_next = target_next;
            pend_next = 1'b0;
        end

        result.heat_on            = mode_next == MODE_HEAT;
        result.cooler_on          = mode_next == MODE_COOL;
        result.active_mode        = mode_next;
        result.running            = mode_next != MODE_IDLE;
        result.transition_pending = pend_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            pend_reg   <= 1'b0;
            target_reg <= MODE_IDLE;
            due_reg    <= '0;
            rest_reg   <= 1'b0;
        end else if (step) begin
            mode_reg   <= mode_next;
            pend_reg   <= pend_next;
            target_reg <= target_next;
            due_reg    <= due_next;
            rest_reg   <= rest_next;
        end
    end

    `TMC_ASSERT_NEXT(a_state_holds_idle, aclk, aresetn, !step,
        $stable(mode_reg) && $stable(pend_reg) && $stable(rest_reg),
        "controller state changed without a transaction")
    `TMC_ASSERT_SAME(a_mode_change_clears_pending, aclk, aresetn,
        step && mode_next != mode_reg, !pend_next,
        "mode changed while a transition stays pending")
    `TMC_ASSERT_SAME(a_pending_differs, aclk, aresetn, pend_reg,
        target_reg != mode_reg, "pending target equals current mode")

endmodule

/* design/thermostat_mode_controller.sv */
// A transaction accepted on the s side reaches m_data through
// two register stages: input register, then result register.
// Throughput: one transaction per cycle; s_ready drops only while both stages hold
// data and m_ready is low.
// Reset: aresetn is synchronous, active low; it empties both stages, sets the mode to
// idle with nothing pending and loads the register defaults (hysteresis 16).
`include "thermostat_mode_controller_defines.svh"

module thermostat_mode_controller (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  tmc_pkg::tmc_in_t                 s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output tmc_pkg::tmc_out_t                m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tmc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tmc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tmc_pkg::*;

    tmc_cfg_t cfg;
    tmc_in_t  in_data_reg;
    logic     in_valid_reg;
    tmc_out_t out_data_reg;
    logic     out_valid_reg;
    tmc_out_t result;
    logic     advance;

    tmc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tmc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_data_reg),
        .cfg     (cfg),
        .result  (result)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

    `TMC_ASSERT_SAME(a_stall_only_when_full, aclk, aresetn, !s_ready,
        in_valid_reg && out_valid_reg && !m_ready,
        "input stalled while the pipeline has room")
    `TMC_ASSERT_SAME(a_outputs_agree, aclk, aresetn, m_valid,
        (m_data.running == (m_data.heat_on || m_data.cooler_on))
        && !(m_data.heat_on && m_data.cooler_on),
        "result flags disagree with each other")
    `TMC_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_data), "result changed before it was taken")

endmodule
